// File: src/peq_pkg.sv
`timescale 1ns / 1ps

package peq_pkg;

	localparam int PEQ_CAPACITY     = 7;
	localparam int PEQ_PAYLOAD_BITS = 32;
	localparam int PEQ_ID_W         = 32;
	localparam int PEQ_ATT_W        = 8;
	localparam int PEQ_BACKOFF_W    = 19;
	localparam int PEQ_COUNT_W      = 3;

	localparam logic [PEQ_BACKOFF_W-1:0] PEQ_BASE_MS    = 19'd2000;
	localparam logic [PEQ_BACKOFF_W-1:0] PEQ_MAX_MS     = 19'd300000;
	localparam logic [PEQ_ATT_W-1:0]     PEQ_MAX_SHIFT  = 8'd8;
	localparam logic [PEQ_ATT_W-1:0]     PEQ_ATT_SAT    = 8'd255;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_PEEK  = 2'd1,
		ACT_ACK   = 2'd2,
		ACT_RETRY = 2'd3
	} action_t;

	// which result the datapath captures on this edge
	typedef enum logic [2:0] {
		RES_NONE      = 3'd0,
		RES_REJECT    = 3'd1,
		RES_PUSH      = 3'd2,
		RES_ACK       = 3'd3,
		RES_RETRY     = 3'd4,
		RES_PEEK_RD   = 3'd5,
		RES_PEEK_HEAD = 3'd6
	} res_t;

	typedef struct packed {
		logic load;
		logic ptr_adv;
		logic pos_inc;
		logic mark_dst;
		logic keep_head;
		logic cp_wr;
		logic retry_wr;
		logic push_wr;
		logic cnt_dec;
		logic drop_head;
		res_t res;
	} peq_cmd_t;

	typedef struct packed {
		action_t action;
		logic    kind;
		logic    full;
		logic    empty;
		logic    hit;
		logic    pos_first;
		logic    pos_last;
	} peq_stat_t;

	function automatic logic [PEQ_BACKOFF_W-1:0] backoff_delay(input logic [PEQ_ATT_W-1:0] att);
		logic [PEQ_BACKOFF_W-1:0] v;
		if (att >= PEQ_MAX_SHIFT) begin
			v = PEQ_MAX_MS;
		end else begin
			v = PEQ_BASE_MS << att[2:0];
		end
		return v;
	endfunction

endpackage

// File: src/peq_ram.sv
`timescale 1ns / 1ps

module peq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/peq_ctrl.sv
`timescale 1ns / 1ps

module peq_ctrl
	import peq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  peq_stat_t stat,
	output peq_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_DISPATCH = 8'b0000_0010,
		ST_SC_RD    = 8'b0000_0100,
		ST_SC_CHK   = 8'b0000_1000,
		ST_CP_TEST  = 8'b0001_0000,
		ST_CP_WAIT  = 8'b0010_0000,
		ST_CP_WR    = 8'b0100_0000,
		ST_PUSH_WR  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res = RES_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.action == ACT_PUSH) begin
					if (!stat.full) begin
						state_d = ST_PUSH_WR;
					end else if (stat.kind) begin
						state_d = ST_SC_RD;
					end else begin
						cmd.res = RES_REJECT;
						state_d = ST_IDLE;
					end
				end else if (stat.empty) begin
					cmd.res = RES_REJECT;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SC_RD;
				end
			end
			ST_SC_RD: begin
				state_d = ST_SC_CHK;
			end
			ST_SC_CHK: begin
				cmd.keep_head = stat.pos_first;
				if (stat.hit) begin
					case (stat.action)
						ACT_PEEK: begin
							cmd.res = RES_PEEK_RD;
							state_d = ST_IDLE;
						end
						ACT_RETRY: begin
							cmd.retry_wr = 1'b1;
							cmd.res      = RES_RETRY;
							state_d      = ST_IDLE;
						end
						default: begin
							// remove the hit entry: close the gap behind it
							cmd.mark_dst = 1'b1;
							cmd.ptr_adv  = 1'b1;
							state_d      = ST_CP_TEST;
						end
					endcase
				end else if (stat.pos_last) begin
					case (stat.action)
						ACT_PUSH: begin
							// all entries are SOS: drop the head
							cmd.drop_head = 1'b1;
							state_d       = ST_PUSH_WR;
						end
						ACT_PEEK: begin
							cmd.res = RES_PEEK_HEAD;
							state_d = ST_IDLE;
						end
						default: begin
							cmd.res = RES_REJECT;
							state_d = ST_IDLE;
						end
					endcase
				end else begin
					cmd.ptr_adv = 1'b1;
					cmd.pos_inc = 1'b1;
					state_d     = ST_SC_RD;
				end
			end
			ST_CP_TEST: begin
				if (stat.pos_last) begin
					cmd.cnt_dec = 1'b1;
					if (stat.action == ACT_PUSH) begin
						state_d = ST_PUSH_WR;
					end else begin
						cmd.res = RES_ACK;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_CP_WAIT;
				end
			end
			ST_CP_WAIT: begin
				state_d = ST_CP_WR;
			end
			ST_CP_WR: begin
				cmd.cp_wr    = 1'b1;
				cmd.mark_dst = 1'b1;
				cmd.ptr_adv  = 1'b1;
				cmd.pos_inc  = 1'b1;
				state_d      = ST_CP_TEST;
			end
			ST_PUSH_WR: begin
				cmd.push_wr = 1'b1;
				cmd.res     = RES_PUSH;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_load_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load issued outside idle");

	a_result_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res != RES_NONE) |=> !busy)
		else $error("block still busy after a result");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH_WR) |-> !stat.full)
		else $error("push write into a full queue");

endmodule

// File: src/peq_dpath.sv
`timescale 1ns / 1ps

module peq_dpath
	import peq_pkg::*;
#(
	parameter int CAPACITY     = PEQ_CAPACITY,
	parameter int PAYLOAD_BITS = PEQ_PAYLOAD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [1:0]               action,
	input  logic                     event_kind,
	input  logic [PAYLOAD_BITS-1:0]  event_payload,
	input  logic [PEQ_ID_W-1:0]      target_id,
	input  peq_cmd_t                 cmd,
	output peq_stat_t                stat,
	output logic                     done,
	output logic                     ok,
	output logic [PEQ_ID_W-1:0]      out_id,
	output logic                     out_kind,
	output logic [PAYLOAD_BITS-1:0]  out_payload,
	output logic [PEQ_ATT_W-1:0]     out_attempts,
	output logic [PEQ_BACKOFF_W-1:0] out_backoff_ms,
	output logic [PEQ_COUNT_W-1:0]   queue_count
);

	localparam int IW      = $clog2(CAPACITY);
	localparam int CW      = $clog2(CAPACITY + 1);
	localparam int SW      = CW + 1;
	localparam int EW      = 1 + PAYLOAD_BITS + PEQ_ID_W + PEQ_ATT_W;
	localparam int ID_LO   = PEQ_ATT_W;
	localparam int PAY_LO  = PEQ_ATT_W + PEQ_ID_W;

	// queue registers
	logic [IW-1:0]       head_q, ptr_q, dst_q;
	logic [CW-1:0]       count_q, pos_q;
	logic [PEQ_ID_W-1:0] seq_q;

	// latched item
	action_t                 action_q;
	logic                    kind_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [PEQ_ID_W-1:0]     target_q;

	// head entry kept for a peek that finds no SOS
	logic [EW-1:0] head_ent_q;
	logic [EW-1:0] head_ent;

	logic [EW-1:0]   rdata, wdata;
	logic [IW-1:0]   waddr;
	logic            we;

	logic                    rd_kind;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic [PEQ_ID_W-1:0]     rd_id;
	logic [PEQ_ATT_W-1:0]    rd_att, att_inc;

	logic [IW-1:0]       ptr_next, dst_next, head_next, tail;
	logic [SW-1:0]       tail_sum;
	logic [PEQ_ID_W-1:0] seq_next;

	logic                     done_q, ok_q, okind_q;
	logic [PEQ_ID_W-1:0]      oid_q;
	logic [PAYLOAD_BITS-1:0]  opay_q;
	logic [PEQ_ATT_W-1:0]     oatt_q;
	logic [PEQ_BACKOFF_W-1:0] oback_q;
	logic [CW+PEQ_COUNT_W-1:0] count_ext;

	logic                     ok_d, okind_d;
	logic [PEQ_ID_W-1:0]      oid_d;
	logic [PAYLOAD_BITS-1:0]  opay_d;
	logic [PEQ_ATT_W-1:0]     oatt_d;
	logic [PEQ_BACKOFF_W-1:0] oback_d;

	assign rd_kind = rdata[EW-1];
	assign rd_pay  = rdata[PAY_LO +: PAYLOAD_BITS];
	assign rd_id   = rdata[ID_LO +: PEQ_ID_W];
	assign rd_att  = rdata[PEQ_ATT_W-1:0];
	assign att_inc = (rd_att == PEQ_ATT_SAT) ? rd_att : rd_att + PEQ_ATT_W'(1);

	// a single-entry queue captures and reports the head on the same edge
	assign head_ent = cmd.keep_head ? rdata : head_ent_q;

	assign ptr_next  = (ptr_q == IW'(CAPACITY - 1)) ? '0 : ptr_q + IW'(1);
	assign dst_next  = (dst_q == IW'(CAPACITY - 1)) ? '0 : dst_q + IW'(1);
	assign head_next = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail      = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
	                                               : IW'(tail_sum);
	assign seq_next  = seq_q + PEQ_ID_W'(1);

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = rdata;
		if (cmd.push_wr) begin
			we    = 1'b1;
			waddr = tail;
			wdata = {kind_q, payload_q, seq_next, PEQ_ATT_W'(0)};
		end else if (cmd.cp_wr) begin
			we    = 1'b1;
			waddr = dst_q;
		end else if (cmd.retry_wr) begin
			we    = 1'b1;
			wdata = {rd_kind, rd_pay, rd_id, att_inc};
		end
	end

	peq_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	always_comb begin
		stat.action    = action_q;
		stat.kind      = kind_q;
		stat.full      = (count_q == CW'(CAPACITY));
		stat.empty     = (count_q == '0);
		stat.pos_first = (pos_q == '0);
		stat.pos_last  = ((SW'(pos_q) + SW'(1)) >= SW'(count_q));
		case (action_q)
			ACT_PUSH: stat.hit = !rd_kind;
			ACT_PEEK: stat.hit = rd_kind;
			default:  stat.hit = (rd_id == target_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			seq_q    <= '0;
			ptr_q    <= '0;
			dst_q    <= '0;
			pos_q    <= '0;
			action_q <= ACT_PUSH;
			done_q   <= 1'b0;
		end else begin
			done_q <= (cmd.res != RES_NONE);
			if (cmd.load) begin
				action_q <= action_t'(action);
				ptr_q    <= head_q;
				pos_q    <= '0;
			end else if (cmd.ptr_adv) begin
				ptr_q <= ptr_next;
			end
			if (cmd.pos_inc) begin
				pos_q <= pos_q + CW'(1);
			end
			if (cmd.mark_dst) begin
				dst_q <= ptr_q;
			end
			if (cmd.drop_head) begin
				head_q <= head_next;
			end
			if (cmd.push_wr) begin
				seq_q   <= seq_next;
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec || cmd.drop_head) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_comb begin
		ok_d    = 1'b0;
		oid_d   = '0;
		okind_d = 1'b0;
		opay_d  = '0;
		oatt_d  = '0;
		oback_d = '0;
		case (cmd.res)
			RES_PUSH: begin
				ok_d  = 1'b1;
				oid_d = seq_next;
			end
			RES_ACK: begin
				ok_d  = 1'b1;
				oid_d = target_q;
			end
			RES_RETRY: begin
				ok_d    = 1'b1;
				oid_d   = target_q;
				oatt_d  = att_inc;
				oback_d = backoff_delay(att_inc);
			end
			RES_PEEK_RD: begin
				ok_d    = 1'b1;
				oid_d   = rd_id;
				okind_d = rd_kind;
				opay_d  = rd_pay;
				oatt_d  = rd_att;
				oback_d = backoff_delay(rd_att);
			end
			RES_PEEK_HEAD: begin
				ok_d    = 1'b1;
				oid_d   = head_ent[ID_LO +: PEQ_ID_W];
				okind_d = head_ent[EW-1];
				opay_d  = head_ent[PAY_LO +: PAYLOAD_BITS];
				oatt_d  = head_ent[PEQ_ATT_W-1:0];
				oback_d = backoff_delay(head_ent[PEQ_ATT_W-1:0]);
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= event_kind;
			payload_q <= event_payload;
			target_q  <= target_id;
		end
		if (cmd.keep_head) begin
			head_ent_q <= rdata;
		end
		if (cmd.res != RES_NONE) begin
			ok_q    <= ok_d;
			oid_q   <= oid_d;
			okind_q <= okind_d;
			opay_q  <= opay_d;
			oatt_q  <= oatt_d;
			oback_q <= oback_d;
		end
	end

	assign count_ext      = (CW + PEQ_COUNT_W)'(count_q);
	assign queue_count    = count_ext[PEQ_COUNT_W-1:0];
	assign done           = done_q;
	assign ok             = ok_q;
	assign out_id         = oid_q;
	assign out_kind       = okind_q;
	assign out_payload    = opay_q;
	assign out_attempts   = oatt_q;
	assign out_backoff_ms = oback_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < IW'(CAPACITY) || CAPACITY == (1 << IW))
		else $error("head index outside the ring");

	a_compact_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cp_wr |-> ptr_q == dst_next)
		else $error("compaction source is not the slot after its destination");

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push_wr, cmd.cp_wr, cmd.retry_wr}))
		else $error("two writers on the slot memory");

endmodule

// File: src/priority_eviction_event_queue_top.sv
`timescale 1ns / 1ps

// Bounded event queue with SOS priority and telemetry eviction.
// Command channel: drive action, event_kind, event_payload and target_id and
// raise start; the command transfers on a clock edge where start is high and
// busy is low. busy stays high while the command is worked on.
// Result channel: done pulses for exactly one cycle; ok, out_id, out_kind,
// out_payload, out_attempts, out_backoff_ms and queue_count are valid in that
// cycle. The receiver cannot hold a result off, and busy is already low while
// done is high, so a new command may transfer in the same cycle.
// The slot memory has a registered read, so the age-order search passes a
// read state and a check state for every slot visited, and closing the gap
// passes a test, a wait and a write state for every slot moved. A push into a
// queue with room goes from dispatch straight to the push write; peek, ack and
// retry search from the head until the hit, and ack then moves the entries
// behind it. The worst case is an SOS push into a full queue whose head is
// telemetry (CAPACITY defaults to seven).
// Reset: arst_n clears the queue to empty and the id counter to zero; slot
// contents are not cleared and are never read before being written.

module priority_eviction_event_queue_top
	import peq_pkg::*;
#(
	parameter int CAPACITY     = PEQ_CAPACITY,
	parameter int PAYLOAD_BITS = PEQ_PAYLOAD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic                     event_kind,
	input  logic [PAYLOAD_BITS-1:0]  event_payload,
	input  logic [PEQ_ID_W-1:0]      target_id,
	output logic                     done,
	output logic                     ok,
	output logic [PEQ_ID_W-1:0]      out_id,
	output logic                     out_kind,
	output logic [PAYLOAD_BITS-1:0]  out_payload,
	output logic [PEQ_ATT_W-1:0]     out_attempts,
	output logic [PEQ_BACKOFF_W-1:0] out_backoff_ms,
	output logic [PEQ_COUNT_W-1:0]   queue_count
);

	peq_cmd_t  cmd;
	peq_stat_t stat;

	peq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	peq_dpath #(
		.CAPACITY     (CAPACITY),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.action         (action),
		.event_kind     (event_kind),
		.event_payload  (event_payload),
		.target_id      (target_id),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.ok             (ok),
		.out_id         (out_id),
		.out_kind       (out_kind),
		.out_payload    (out_payload),
		.out_attempts   (out_attempts),
		.out_backoff_ms (out_backoff_ms),
		.queue_count    (queue_count)
	);

endmodule
